// ----- rtl/ots_pkg.sv -----
package ots_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_W    = 8;
	localparam int US_W    = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_REMOVED   = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_EXPIRED   = 3'd4,
		KIND_SUMMARY   = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [ID_W-1:0]     id;
		logic [US_W-1:0]     min_rem;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} res_t;

endpackage

// ----- rtl/ots_res_reg.sv -----
module ots_res_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  ots_pkg::res_t                 res_in,
	output logic                          free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    result_kind,
	output logic [ots_pkg::ID_W-1:0]      expired_id,
	output logic [ots_pkg::US_W-1:0]      min_remaining_us,
	output logic [ots_pkg::COUNT_W-1:0]   entry_count,
	output logic                          last
);
	import ots_pkg::*;

	logic valid_q;
	res_t res_q;

	// a slot is free when empty or when its beat is taken this cycle
	assign free = !valid_q || out_ready;

	// hold the result beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			res_q <= res_in;
		end
	end

	assign out_valid        = valid_q;
	assign result_kind      = res_q.kind;
	assign expired_id       = res_q.id;
	assign min_remaining_us = res_q.min_rem;
	assign entry_count      = res_q.count;
	assign last             = res_q.last;

endmodule

// ----- rtl/one_shot_timer_table.sv -----
// One-shot timer table: up to sixteen timers kept in insertion order in a
// single-port-read, single-port-write entry memory, one request at a time.
// An add writes the new entry on acceptance, then waits for the result register.
// A remove walks the n live entries through the memory read port, one per cycle,
// shifting later entries down once the first match is dropped.
// A tick walks the n entries the same way, subtracting elapsed time with
// saturation and compacting survivors, while the ids of expired entries go
// into a small id buffer; it then reads that buffer back, one expired beat per
// buffered id, and ends with the summary beat. All beats of a request carry
// the final entry count. Every result beat sits in an output register, so a
// slow sink only stalls the request that is producing beats.
module one_shot_timer_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [ots_pkg::ID_W-1:0]      timer_id,
	input  logic [ots_pkg::US_W-1:0]      timeout_us,
	input  logic [ots_pkg::US_W-1:0]      elapsed_us,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    result_kind,
	output logic [ots_pkg::ID_W-1:0]      expired_id,
	output logic [ots_pkg::US_W-1:0]      min_remaining_us,
	output logic [ots_pkg::COUNT_W-1:0]   entry_count,
	output logic                          last
);
	import ots_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP,
		ST_GREAD,
		ST_GPUSH
	} state_t;

	state_t             state_q;
	logic [1:0]         req_q;
	logic [ID_W-1:0]    id_q;
	logic [US_W-1:0]    elapsed_q;
	kind_t              kind_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   keep_q;
	logic [CNT_W-1:0]   ngone_q;
	logic [CNT_W-1:0]   em_idx_q;
	logic [US_W-1:0]    min_q;
	logic               found_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   idx_s1;

	// entry memory and expired id buffer
	logic [ID_W+US_W-1:0] ent_mem [DEPTH];
	logic [ID_W-1:0]      gone_mem [DEPTH];
	logic [ID_W+US_W-1:0] ent_rdata_s1;
	logic [ID_W-1:0]      gone_rdata_s1;

	logic                 ent_re;
	logic                 ent_we;
	logic [IDX_W-1:0]     ent_wa;
	logic [ID_W+US_W-1:0] ent_wd;
	logic                 gone_re;
	logic                 gone_we;

	logic                 in_fire;
	logic [ID_W-1:0]      ent_id;
	logic [US_W-1:0]      ent_rem;
	logic                 expire;
	logic [US_W-1:0]      rem_new;

	logic                 res_push;
	logic                 res_free;
	res_t                 res_d;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign ent_id  = ent_rdata_s1[ID_W+US_W-1:US_W];
	assign ent_rem = ent_rdata_s1[US_W-1:0];
	assign expire  = (ent_rem <= elapsed_q);
	assign rem_new = ent_rem - elapsed_q;

	// issue walk reads and expired id reads
	assign ent_re  = (state_q == ST_WALK) && (rd_idx_q < count_q);
	assign gone_re = (state_q == ST_GREAD) && (em_idx_q < ngone_q);

	// select the memory write for add, compaction or shift
	always_comb begin
		ent_we  = 1'b0;
		ent_wa  = '0;
		ent_wd  = '0;
		gone_we = 1'b0;
		if (in_fire && req_type == REQ_ADD && count_q < CNT_W'(DEPTH)) begin
			ent_we = 1'b1;
			ent_wa = count_q[IDX_W-1:0];
			ent_wd = {timer_id, timeout_us};
		end else if (state_q == ST_WALK && pend_s1) begin
			if (req_q == REQ_TICK) begin
				if (expire) begin
					gone_we = 1'b1;
				end else begin
					ent_we = 1'b1;
					ent_wa = keep_q[IDX_W-1:0];
					ent_wd = {ent_id, rem_new};
				end
			end else if (found_q) begin
				ent_we = 1'b1;
				ent_wa = IDX_W'(idx_s1 - 1'b1);
				ent_wd = ent_rdata_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (ent_re) begin
			ent_rdata_s1 <= ent_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (gone_we) begin
			gone_mem[ngone_q[IDX_W-1:0]] <= ent_id;
		end
		if (gone_re) begin
			gone_rdata_s1 <= gone_mem[em_idx_q[IDX_W-1:0]];
		end
	end

	// sequence requests through the walk and the result beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			req_q     <= '0;
			id_q      <= '0;
			elapsed_q <= '0;
			kind_q    <= KIND_ADDED;
			count_q   <= '0;
			rd_idx_q  <= '0;
			keep_q    <= '0;
			ngone_q   <= '0;
			em_idx_q  <= '0;
			min_q     <= '1;
			found_q   <= 1'b0;
			pend_s1   <= 1'b0;
			idx_s1    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						req_q     <= req_type;
						id_q      <= timer_id;
						elapsed_q <= elapsed_us;
						rd_idx_q  <= '0;
						keep_q    <= '0;
						ngone_q   <= '0;
						found_q   <= 1'b0;
						pend_s1   <= 1'b0;
						min_q     <= '1;
						unique case (req_type)
							REQ_ADD: begin
								if (count_q < CNT_W'(DEPTH)) begin
									kind_q  <= KIND_ADDED;
									count_q <= count_q + 1'b1;
								end else begin
									kind_q <= KIND_FULL;
								end
								state_q <= ST_RESP;
							end
							REQ_REMOVE, REQ_TICK: begin
								state_q <= ST_WALK;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					pend_s1 <= ent_re;
					if (ent_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						idx_s1   <= rd_idx_q[IDX_W-1:0];
					end
					if (pend_s1) begin
						if (req_q == REQ_TICK) begin
							if (expire) begin
								ngone_q <= ngone_q + 1'b1;
							end else begin
								keep_q <= keep_q + 1'b1;
								if (rem_new < min_q) begin
									min_q <= rem_new;
								end
							end
						end else if (!found_q && ent_id == id_q) begin
							found_q <= 1'b1;
						end
					end
					if (!ent_re && !pend_s1) begin
						if (req_q == REQ_TICK) begin
							count_q  <= keep_q;
							em_idx_q <= '0;
							state_q  <= ST_GREAD;
						end else begin
							if (found_q) begin
								kind_q  <= KIND_REMOVED;
								count_q <= count_q - 1'b1;
							end else begin
								kind_q <= KIND_NOT_FOUND;
							end
							state_q <= ST_RESP;
						end
					end
				end
				ST_GREAD: begin
					if (gone_re) begin
						state_q <= ST_GPUSH;
					end else begin
						kind_q  <= KIND_SUMMARY;
						state_q <= ST_RESP;
					end
				end
				ST_GPUSH: begin
					if (res_free) begin
						em_idx_q <= em_idx_q + 1'b1;
						state_q  <= ST_GREAD;
					end
				end
				ST_RESP: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// build the result beat for the output register
	always_comb begin
		res_push      = 1'b0;
		res_d.kind    = kind_q;
		res_d.id      = id_q;
		res_d.min_rem = '0;
		res_d.count   = COUNT_W'(count_q);
		res_d.last    = 1'b1;
		unique case (state_q)
			ST_RESP: begin
				res_push = res_free;
				if (kind_q == KIND_SUMMARY) begin
					res_d.id      = '0;
					res_d.min_rem = min_q;
				end
			end
			ST_GPUSH: begin
				res_push   = res_free;
				res_d.kind = KIND_EXPIRED;
				res_d.id   = gone_rdata_s1;
				res_d.last = 1'b0;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	ots_res_reg u_res_reg (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (res_push),
		.res_in           (res_d),
		.free             (res_free),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.expired_id       (expired_id),
		.min_remaining_us (min_remaining_us),
		.entry_count      (entry_count),
		.last             (last)
	);

	// compaction and shift writes stay behind the read pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		(ent_we && ent_re) |-> ({1'b0, ent_wa} < {1'b0, rd_idx_q}))
		else $error("entry write overtakes walk read");

	// every processed entry is either kept or expired, never more
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |->
		(({1'b0, keep_q} + {1'b0, ngone_q}) <= {1'b0, rd_idx_q}))
		else $error("walk accounting exceeds entries read");

	// live count never exceeds the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("live count beyond depth");

	// an expired beat is only pushed for a buffered id
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GPUSH) |-> (em_idx_q < ngone_q))
		else $error("expired beat without buffered id");

endmodule

// ----- bench/one_shot_timer_table_test.sv -----
module one_shot_timer_table_test;
	import ots_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 410;
	localparam int QUIET_LIMIT  = 2000;
	localparam int END_SETTLE   = 100;
	localparam int PRINT_CAP    = 40;

	typedef struct {
		logic [1:0]      req;
		logic [ID_W-1:0] id;
		logic [US_W-1:0] tmo;
		logic [US_W-1:0] ela;
		int              reps;
		bit              typed;
		res_t            want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          req_type = REQ_ADD;
	logic [ID_W-1:0]     timer_id = '0;
	logic [US_W-1:0]     timeout_us = '0;
	logic [US_W-1:0]     elapsed_us = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          result_kind;
	logic [ID_W-1:0]     expired_id;
	logic [US_W-1:0]     min_remaining_us;
	logic [COUNT_W-1:0]  entry_count;
	logic                last;

	// typed expectation travelling with the request on the input channel
	bit                  held_typed = 1'b0;
	res_t                held_want = '0;

	// shadow timer table, advanced on every accepted request
	logic [ID_W-1:0]     tbl_id [DEPTH];
	logic [US_W-1:0]     tbl_left [DEPTH];
	int                  tbl_count = 0;
	res_t                timer_beats_due [$];
	plan_row_t           plan [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int beats_checked = 0;
	int requests_taken = 0;
	int expiries_due = 0;
	int full_rejects = 0;
	int missing_removes = 0;
	int ignored_reqs = 0;
	int peak_count = 0;
	int quiet_cycles = 0;

	one_shot_timer_table DUT (.*);

	always #5 clk = ~clk;

	function automatic res_t make_beat(kind_t kind, logic [ID_W-1:0] id,
			logic [US_W-1:0] min_rem, logic last_beat);
		res_t b;
		b.kind = kind;
		b.id = id;
		b.min_rem = min_rem;
		b.count = COUNT_W'(tbl_count);
		b.last = last_beat;
		return b;
	endfunction

	// apply one request to the shadow table and queue the beats it owes
	task automatic advance_timer_table(input logic [1:0] req, input logic [ID_W-1:0] id,
			input logic [US_W-1:0] tmo, input logic [US_W-1:0] ela);
		int k;
		int keep;
		logic [US_W-1:0] left;
		logic [US_W-1:0] low;
		logic [ID_W-1:0] gone [$];
		case (req)
			REQ_ADD: begin
				if (tbl_count >= DEPTH) begin
					full_rejects++;
					timer_beats_due.push_back(make_beat(KIND_FULL, id, '0, 1'b1));
				end else begin
					tbl_id[tbl_count] = id;
					tbl_left[tbl_count] = tmo;
					tbl_count++;
					if (tbl_count > peak_count)
						peak_count = tbl_count;
					timer_beats_due.push_back(make_beat(KIND_ADDED, id, '0, 1'b1));
				end
			end
			REQ_REMOVE: begin
				k = 0;
				while (k < tbl_count && tbl_id[k] != id)
					k++;
				if (k == tbl_count) begin
					missing_removes++;
					timer_beats_due.push_back(make_beat(KIND_NOT_FOUND, id, '0, 1'b1));
				end else begin
					// close the gap left by the first match
					while (k + 1 < tbl_count) begin
						tbl_id[k] = tbl_id[k + 1];
						tbl_left[k] = tbl_left[k + 1];
						k++;
					end
					tbl_count--;
					timer_beats_due.push_back(make_beat(KIND_REMOVED, id, '0, 1'b1));
				end
			end
			REQ_TICK: begin
				keep = 0;
				low = '1;
				// subtract with saturation, compact survivors, collect the expired
				for (k = 0; k < tbl_count; k++) begin
					left = (tbl_left[k] > ela) ? tbl_left[k] - ela : '0;
					if (left == '0) begin
						gone.push_back(tbl_id[k]);
					end else begin
						tbl_id[keep] = tbl_id[k];
						tbl_left[keep] = left;
						if (left < low)
							low = left;
						keep++;
					end
				end
				tbl_count = keep;
				expiries_due += gone.size();
				foreach (gone[g])
					timer_beats_due.push_back(make_beat(KIND_EXPIRED, gone[g], '0, 1'b0));
				timer_beats_due.push_back(make_beat(KIND_SUMMARY, '0, low, 1'b1));
			end
			default: ignored_reqs++;
		endcase
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	task automatic plan_step(input logic [1:0] req, input logic [ID_W-1:0] id,
			input logic [US_W-1:0] tmo, input logic [US_W-1:0] ela, input int reps,
			input bit typed, input kind_t kind, input logic [US_W-1:0] min_rem,
			input int cnt);
		plan_row_t row;
		row.req = req;
		row.id = id;
		row.tmo = tmo;
		row.ela = ela;
		row.reps = reps;
		row.typed = typed;
		row.want.kind = kind;
		row.want.id = id;
		row.want.min_rem = min_rem;
		row.want.count = COUNT_W'(cnt);
		row.want.last = 1'b1;
		plan.push_back(row);
	endtask

	// present one request from a falling edge, hold it until accepted,
	// and come back on the next falling edge
	task automatic send_item(input logic [1:0] req, input logic [ID_W-1:0] id,
			input logic [US_W-1:0] tmo, input logic [US_W-1:0] ela,
			input bit typed, input res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		timer_id <= id;
		timeout_us <= tmo;
		elapsed_us <= ela;
		held_typed <= typed;
		held_want <= want;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// stall the result channel at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// predict on each accepted request, check each accepted beat
	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				requests_taken++;
				advance_timer_table(req_type, timer_id, timeout_us, elapsed_us);
				if (held_typed) begin
					// the typed row stands in for the shadow's single beat
					void'(timer_beats_due.pop_back());
					timer_beats_due.push_back(held_want);
				end
			end
			if (out_valid && out_ready) begin
				beats_checked++;
				if (timer_beats_due.size() == 0) begin
					report_mismatch($sformatf("beat with nothing outstanding: kind %0d id %0d",
						result_kind, expired_id));
				end else begin
					want = timer_beats_due.pop_front();
					if (result_kind !== want.kind)
						report_mismatch($sformatf("result_kind %0d, want %0d",
							result_kind, want.kind));
					if (expired_id !== want.id)
						report_mismatch($sformatf("expired_id %0d, want %0d",
							expired_id, want.id));
					if (min_remaining_us !== want.min_rem)
						report_mismatch($sformatf("min_remaining_us %0d, want %0d",
							min_remaining_us, want.min_rem));
					if (entry_count !== want.count)
						report_mismatch($sformatf("entry_count %0d, want %0d",
							entry_count, want.count));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b", last, want.last));
				end
			end
		end
	end

	// give up once neither channel has moved a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d beats still due",
				QUIET_LIMIT, timer_beats_due.size());
			$display("[one_shot_timer_table] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int sent;
		int chunk;
		int pick;
		int r;
		logic [1:0]      req;
		logic [ID_W-1:0] id;
		logic [US_W-1:0] tmo;
		logic [US_W-1:0] ela;

		// directed rows: empty table, extremes, zero timeout, duplicates, full table
		plan_step(REQ_TICK, 8'h00, '0, '0, 1, 1, KIND_SUMMARY, '1, 0);
		plan_step(REQ_REMOVE, 8'h00, '0, '0, 1, 1, KIND_NOT_FOUND, '0, 0);
		plan_step(REQ_UNUSED, 8'hFF, '1, '1, 1, 0, KIND_ADDED, '0, 0);
		plan_step(REQ_ADD, 8'hFF, '1, '0, 1, 1, KIND_ADDED, '0, 1);
		plan_step(REQ_ADD, 8'h00, '0, '0, 1, 1, KIND_ADDED, '0, 2);
		plan_step(REQ_TICK, 8'h00, '0, '0, 1, 0, KIND_ADDED, '0, 0);
		plan_step(REQ_ADD, 8'hA5, 32'd1, '0, 1, 1, KIND_ADDED, '0, 2);
		plan_step(REQ_ADD, 8'hA5, 32'd100, '0, 1, 1, KIND_ADDED, '0, 3);
		plan_step(REQ_REMOVE, 8'hA5, '0, '0, 1, 1, KIND_REMOVED, '0, 2);
		plan_step(REQ_REMOVE, 8'h5A, '0, '0, 1, 1, KIND_NOT_FOUND, '0, 2);
		plan_step(REQ_TICK, 8'h00, '0, 32'd50, 1, 0, KIND_ADDED, '0, 0);
		plan_step(REQ_ADD, 8'h10, 32'd200, '0, 14, 0, KIND_ADDED, '0, 0);
		plan_step(REQ_ADD, 8'h77, 32'd5, '0, 1, 1, KIND_FULL, '0, 16);
		plan_step(REQ_TICK, 8'h00, '0, '1, 1, 0, KIND_ADDED, '0, 0);
		plan_step(REQ_TICK, 8'h00, '0, '0, 1, 1, KIND_SUMMARY, '1, 0);

		// hold reset, release on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed rows with both channels free-running
		foreach (plan[p])
			for (int rep = 0; rep < plan[p].reps; rep++)
				send_item(plan[p].req, plan[p].id + ID_W'(rep), plan[p].tmo + US_W'(rep),
					plan[p].ela, plan[p].typed, plan[p].want);

		// random requests, cycling through the idle and stall patterns
		sent = 0;
		for (chunk = 0; chunk < 8; chunk++) begin
			case (chunk % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 74; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 74; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			while (sent < (chunk + 1) * RANDOM_ITEMS / 8) begin
				pick = $urandom_range(99);
				// ids mostly from a small pool so that duplicates and hits are common
				id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(255))
					: ID_W'($urandom_range(7));
				tmo = $urandom();
				ela = $urandom();
				if (pick < 3) begin
					req = REQ_UNUSED;
				end else if (pick < 46) begin
					req = REQ_ADD;
					r = $urandom_range(19);
					if (r == 0)
						tmo = '0;
					else if (r == 1)
						tmo = '1;
					else if (r > 3)
						tmo = US_W'($urandom_range(1, 600));
				end else if (pick < 70) begin
					req = REQ_REMOVE;
					if (tbl_count > 0 && $urandom_range(3) != 0)
						id = tbl_id[$urandom_range(tbl_count - 1)];
				end else begin
					req = REQ_TICK;
					r = $urandom_range(29);
					if (r == 0)
						ela = '0;
					else if (r == 1)
						ela = '1;
					else if (r < 10 && tbl_count > 0)
						// land on, just short of, or just past a live entry
						ela = tbl_left[$urandom_range(tbl_count - 1)]
							+ US_W'($urandom_range(2)) - US_W'(1);
					else if (r > 2)
						ela = US_W'($urandom_range(150));
				end
				send_item(req, id, tmo, ela, 1'b0, '0);
				if (req != REQ_UNUSED)
					sent++;
			end
		end
		in_valid <= 1'b0;

		// drain, then give any stray beat time to show up
		while (timer_beats_due.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		$display("run: %0d requests (%0d ignored), %0d result beats checked",
			requests_taken, ignored_reqs, beats_checked);
		$display("run: peak %0d of %0d entries, %0d expiries, %0d full, %0d not found",
			peak_count, DEPTH, expiries_due, full_rejects, missing_removes);
		if (mismatches == 0)
			$display("[one_shot_timer_table] OK");
		else
			$display("[one_shot_timer_table] ERROR");
		$finish;
	end

endmodule
